FILE: rtl/core/wosc_pkg.sv
// Shared types, constants and the quarter-wave sine table of the waveform oscillator.
// Depends on nothing; every other file in rtl/core uses it by scoped names.
`default_nettype none

package wosc_pkg;

    // Datapath sizing
    localparam int CHUNK_SIZE      = 32;
    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 8;

    localparam int FREQ_W     = 24;
    localparam int FREQ_FRAC  = 8;
    localparam int SAMPLE_W   = 16;
    localparam int FR_W       = 18;
    localparam int SHAPE_W    = 2;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam int TAB_N      = 1 << SINE_TABLE_BITS;
    localparam int TAB_IDX_W  = SINE_TABLE_BITS + 1;
    localparam int TAB_VAL_W  = SAMPLE_W - 1;

    // Dividend: |freq| scaled to phase units plus half the divisor
    localparam int NUM_W      = FREQ_W + PHASE_BITS - FREQ_FRAC;
    localparam int DIV_ROUNDS = (NUM_W + 1) / 2;
    localparam int DIV_PAD_W  = 2 * DIV_ROUNDS;
    localparam int DIV_CNT_W  = $clog2(DIV_ROUNDS + 1);

    localparam int CNT_W = (CHUNK_SIZE > 1) ? $clog2(CHUNK_SIZE) : 1;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [SHAPE_W-1:0] {
        SHAPE_SINE   = 2'd0,
        SHAPE_SQUARE = 2'd1,
        SHAPE_SAW    = 2'd2
    } t_shape;

    typedef enum logic {
        REG_SHAPE      = 1'b0,
        REG_FRAME_RATE = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RUN
    } t_state;

    typedef struct packed {
        t_shape          shape;
        logic [FR_W-1:0] frame_rate;
    } t_cfg;

    typedef logic [TAB_VAL_W-1:0] t_sine_tab [0:TAB_N];

    // Two Q30 multiplies by the angle: raise the term by x^2
    function automatic logic [63:0] sq_step(input logic [63:0] term, input logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

    // Entry k = round(32768*sin(pi/2*k/N)), capped at 32767, from a Q30 Taylor series; elaboration only
    function automatic t_sine_tab build_sine();
        t_sine_tab          tab;
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        for (int k = 0; k <= TAB_N; k++) begin
            x    = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
            term = x;
            sum  = $signed(x);
            term = sq_step(term, x) / 64'd6;   sum = sum - $signed(term);
            term = sq_step(term, x) / 64'd20;  sum = sum + $signed(term);
            term = sq_step(term, x) / 64'd42;  sum = sum - $signed(term);
            term = sq_step(term, x) / 64'd72;  sum = sum + $signed(term);
            term = sq_step(term, x) / 64'd110; sum = sum - $signed(term);
            term = sq_step(term, x) / 64'd156; sum = sum + $signed(term);
            term = sq_step(term, x) / 64'd210; sum = sum - $signed(term);
            if (sum < 0) begin
                sum = 0;
            end
            v = (sum + 64'sd16384) >>> 15;
            if (v > 64'sd32767) begin
                v = 64'sd32767;
            end
            tab[k] = v[TAB_VAL_W-1:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine();

endpackage

`default_nettype wire

FILE: rtl/core/waveform_oscillator.sv
// Top level of the phase-accumulator waveform oscillator.
// Depends on wosc_pkg, wosc_regs, wosc_div and wosc_wave.
`default_nettype none

// Each frequency transaction (signed hertz, 8 fraction bits) produces a chunk of
// CHUNK_SIZE (32) signed Q1.15 samples, the final one flagged with o_last. The
// frequency is turned into a phase increment, |freq| * 2^(PHASE_BITS-8) divided by
// frame_rate with rounding, by a restoring divider that retires two quotient bits a
// cycle. The sign of freq is then applied modulo one turn, and a frame_rate of zero
// gives a zero increment. The phase accumulator is not cleared between chunks.
// Samples then leave at one per cycle while the sink keeps i_sample_ready high. The
// input is ready only between chunks, but the final sample may still sit in the
// output register while the next frequency is taken. Shape and frame_rate sit at
// APB byte addresses 0 and 4 and may be written only while the block is idle;
// shape code 3 gives silence.
module waveform_oscillator (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // frequency input channel
    input  wire logic                                i_freq_valid,
    output logic                                     o_freq_ready,
    input  wire logic signed [wosc_pkg::FREQ_W-1:0]  i_freq,
    // sample output channel
    output logic                                     o_sample_valid,
    input  wire logic                                i_sample_ready,
    output logic signed [wosc_pkg::SAMPLE_W-1:0]     o_sample,
    output logic                                     o_last,
    // APB configuration port
    input  wire logic                                i_psel,
    input  wire logic                                i_penable,
    input  wire logic                                i_pwrite,
    input  wire logic [wosc_pkg::APB_ADDR_W-1:0]     i_paddr,
    input  wire logic [wosc_pkg::APB_DATA_W-1:0]     i_pwdata,
    output logic      [wosc_pkg::APB_DATA_W-1:0]     o_prdata,
    output logic                                     o_pready
);

    localparam int PB = wosc_pkg::PHASE_BITS;

    wosc_pkg::t_cfg   w_cfg;

    wosc_pkg::t_state r_state;
    wosc_pkg::t_state n_state;

    logic                          r_neg;
    logic                          n_neg;
    logic [PB-1:0]                 r_phase;
    logic [PB-1:0]                 n_phase;
    logic [PB-1:0]                 r_inc;
    logic [PB-1:0]                 n_inc;
    logic [wosc_pkg::CNT_W-1:0]    r_cnt;
    logic [wosc_pkg::CNT_W-1:0]    n_cnt;
    logic [wosc_pkg::SAMPLE_W-1:0] r_sample;
    logic [wosc_pkg::SAMPLE_W-1:0] n_sample;
    logic                          r_last;
    logic                          n_last;
    logic                          r_out_valid;
    logic                          n_out_valid;

    logic                          w_in_xact;
    logic                          w_out_free;
    logic [wosc_pkg::FREQ_W-1:0]   w_mag;
    logic [wosc_pkg::NUM_W-1:0]    w_dividend;
    logic                          w_div_done;
    logic [PB-1:0]                 w_quot;
    logic [wosc_pkg::SAMPLE_W-1:0] w_wave;

    // Configuration registers
    wosc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg)
    );

    // Magnitude of the frequency; the most negative code maps to 2^23 as unsigned
    assign w_mag = i_freq[wosc_pkg::FREQ_W-1] ? (wosc_pkg::FREQ_W'(0) - i_freq) : i_freq;

    // Scale to phase units and add half the divisor to round to nearest
    assign w_dividend = {w_mag, {(PB - wosc_pkg::FREQ_FRAC){1'b0}}}
                      + wosc_pkg::NUM_W'(w_cfg.frame_rate >> 1);

    wosc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_xact),
        .i_dividend (w_dividend),
        .i_divisor  (w_cfg.frame_rate),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    wosc_wave u_wave (
        .i_phase  (r_phase),
        .i_shape  (w_cfg.shape),
        .o_sample (w_wave)
    );

    assign o_freq_ready   = (r_state == wosc_pkg::ST_IDLE);
    assign w_in_xact      = i_freq_valid && o_freq_ready;
    // The output register can take a new sample when empty or being drained
    assign w_out_free     = !r_out_valid || i_sample_ready;

    assign o_sample_valid = r_out_valid;
    assign o_sample       = r_sample;
    assign o_last         = r_last;

    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_phase     = r_phase;
        n_inc       = r_inc;
        n_cnt       = r_cnt;
        n_sample    = r_sample;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_sample_ready;

        unique case (r_state)
            wosc_pkg::ST_IDLE: begin
                if (w_in_xact) begin
                    n_neg   = i_freq[wosc_pkg::FREQ_W-1];
                    n_state = wosc_pkg::ST_DIV;
                end
            end
            wosc_pkg::ST_DIV: begin
                // Latch the increment: drop it for a zero rate, negate for negative freq
                if (w_div_done) begin
                    if (w_cfg.frame_rate == '0) begin
                        n_inc = '0;
                    end else if (r_neg) begin
                        n_inc = PB'(0) - w_quot;
                    end else begin
                        n_inc = w_quot;
                    end
                    n_cnt   = '0;
                    n_state = wosc_pkg::ST_RUN;
                end
            end
            wosc_pkg::ST_RUN: begin
                // Emit the sample at the current phase, then advance the phase
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_sample    = w_wave;
                    n_last      = (r_cnt == wosc_pkg::CNT_W'(wosc_pkg::CHUNK_SIZE - 1));
                    n_phase     = r_phase + r_inc;
                    n_cnt       = r_cnt + 1'b1;
                    if (n_last) begin
                        n_state = wosc_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = wosc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wosc_pkg::ST_IDLE;
            r_phase     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_neg    <= n_neg;
        r_inc    <= n_inc;
        r_sample <= n_sample;
        r_last   <= n_last;
    end

endmodule

`default_nettype wire

FILE: rtl/core/wosc_regs.sv
// APB configuration registers of the waveform oscillator: shape and frame rate.
// Depends on wosc_pkg.
`default_nettype none

module wosc_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_psel,
    input  wire logic                              i_penable,
    input  wire logic                              i_pwrite,
    input  wire logic [wosc_pkg::APB_ADDR_W-1:0]   i_paddr,
    input  wire logic [wosc_pkg::APB_DATA_W-1:0]   i_pwdata,
    output logic      [wosc_pkg::APB_DATA_W-1:0]   o_prdata,
    output logic                                   o_pready,
    output wosc_pkg::t_cfg                         o_cfg
);

    wosc_pkg::t_cfg   r_cfg;
    wosc_pkg::t_cfg   n_cfg;
    wosc_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx    = wosc_pkg::t_reg_idx'(i_paddr[2]);
    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                wosc_pkg::REG_SHAPE:
                    n_cfg.shape = wosc_pkg::t_shape'(i_pwdata[wosc_pkg::SHAPE_W-1:0]);
                wosc_pkg::REG_FRAME_RATE:
                    n_cfg.frame_rate = i_pwdata[wosc_pkg::FR_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            wosc_pkg::REG_SHAPE:
                o_prdata = wosc_pkg::APB_DATA_W'(r_cfg.shape);
            wosc_pkg::REG_FRAME_RATE:
                o_prdata = wosc_pkg::APB_DATA_W'(r_cfg.frame_rate);
            default: o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shape      <= wosc_pkg::SHAPE_SINE;
            r_cfg.frame_rate <= wosc_pkg::FR_W'(48000);
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/wosc_div.sv
// Restoring divider, two quotient bits per cycle, keeping the low PHASE_BITS of the quotient.
// Depends on wosc_pkg.
`default_nettype none

module wosc_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [wosc_pkg::NUM_W-1:0]        i_dividend,
    input  wire logic [wosc_pkg::FR_W-1:0]         i_divisor,
    output logic                                   o_done,
    output logic      [wosc_pkg::PHASE_BITS-1:0]   o_quot
);

    localparam int RW = wosc_pkg::FR_W + 1;

    logic [wosc_pkg::DIV_PAD_W-1:0]  r_num;
    logic [wosc_pkg::FR_W-1:0]       r_rem;
    logic [wosc_pkg::FR_W-1:0]       r_div;
    logic [wosc_pkg::PHASE_BITS-1:0] r_quot;
    logic [wosc_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic                            r_busy;
    logic                            r_done;

    logic [RW-1:0] w_t0;
    logic [RW-1:0] w_t1;
    logic [RW-1:0] w_r0;
    logic [RW-1:0] w_r1;
    logic          w_q0;
    logic          w_q1;

    // First step takes the top dividend bit, second the next one
    always_comb begin
        w_t0 = {r_rem, r_num[wosc_pkg::DIV_PAD_W-1]};
        w_q0 = (w_t0 >= {1'b0, r_div});
        w_r0 = w_q0 ? (w_t0 - {1'b0, r_div}) : w_t0;
        w_t1 = {w_r0[wosc_pkg::FR_W-1:0], r_num[wosc_pkg::DIV_PAD_W-2]};
        w_q1 = (w_t1 >= {1'b0, r_div});
        w_r1 = w_q1 ? (w_t1 - {1'b0, r_div}) : w_t1;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= wosc_pkg::DIV_PAD_W'(i_dividend);
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= r_num << 2;
            r_rem  <= w_r1[wosc_pkg::FR_W-1:0];
            r_quot <= {r_quot[wosc_pkg::PHASE_BITS-3:0], w_q0, w_q1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == wosc_pkg::DIV_CNT_W'(wosc_pkg::DIV_ROUNDS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/wosc_wave.sv
// Phase-to-amplitude mapping: quarter-wave sine, square and sawtooth in Q1.15.
// Depends on wosc_pkg (shape codes and the sine table).
`default_nettype none

module wosc_wave (
    input  wire logic [wosc_pkg::PHASE_BITS-1:0] i_phase,
    input  wosc_pkg::t_shape                     i_shape,
    output logic      [wosc_pkg::SAMPLE_W-1:0]   o_sample
);

    localparam int PB  = wosc_pkg::PHASE_BITS;
    localparam int STB = wosc_pkg::SINE_TABLE_BITS;

    logic [1:0]                        w_quad;
    logic [STB-1:0]                    w_frac;
    logic [wosc_pkg::TAB_IDX_W-1:0]    w_idx;
    logic [wosc_pkg::SAMPLE_W-1:0]     w_mag;
    logic [wosc_pkg::SAMPLE_W-1:0]     w_sine;

    assign w_quad = i_phase[PB-1 -: 2];
    assign w_frac = i_phase[PB-3 -: STB];

    // Odd quadrants read the table mirrored, the second half negates
    always_comb begin
        w_idx  = w_quad[0] ? (wosc_pkg::TAB_IDX_W'(wosc_pkg::TAB_N) - {1'b0, w_frac})
                           : {1'b0, w_frac};
        w_mag  = {1'b0, wosc_pkg::SINE_TAB[w_idx]};
        w_sine = w_quad[1] ? (wosc_pkg::SAMPLE_W'(0) - w_mag) : w_mag;
    end

    always_comb begin
        unique case (i_shape)
            wosc_pkg::SHAPE_SINE:   o_sample = w_sine;
            wosc_pkg::SHAPE_SQUARE: o_sample = i_phase[PB-1] ? 16'h7FFF : 16'h8000;
            wosc_pkg::SHAPE_SAW:    o_sample = {~i_phase[PB-1],
                                                i_phase[PB-2 -: wosc_pkg::SAMPLE_W-1]};
            default:                o_sample = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/wosc_chk.sv
// Port-level checker for waveform_oscillator, bound to the top level below.
// Depends on wosc_pkg for widths.
`default_nettype none

module wosc_chk (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_freq_valid,
    input wire logic                               o_freq_ready,
    input wire logic                               o_sample_valid,
    input wire logic                               i_sample_ready,
    input wire logic [wosc_pkg::SAMPLE_W-1:0]      o_sample,
    input wire logic                               o_last
);

    // Drop ready once a frequency is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_freq_valid && o_freq_ready) |=> !o_freq_ready)
        else $error("input ready held after a frequency transaction");

    // Between chunks the output holds at most the final sample of the previous one
    a_idle_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_freq_ready && o_sample_valid) |-> o_last)
        else $error("mid-chunk sample pending while input is ready");

    // A frequency just taken is not followed at once by a fresh sample, only a held final one
    a_no_sample_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_freq_valid && o_freq_ready) |=> (!o_sample_valid || o_last))
        else $error("sample emitted before the increment was ready");

    // Hold a stalled sample
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_sample_valid && !i_sample_ready) |=>
            (o_sample_valid && $stable(o_sample) && $stable(o_last)))
        else $error("stalled sample transaction changed");

endmodule

bind waveform_oscillator wosc_chk u_chk (.*);

`default_nettype wire

FILE: verif/wosc_checker.sv
// Scoreboard for the waveform oscillator: it watches the frequency, sample and APB ports,
// predicts every chunk of samples from its own copy of the phase and registers, and compares.
// Depends on wosc_pkg for sizes and the register and shape codes.
module wosc_checker
    import wosc_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_freq_valid,
    input  wire logic                       i_freq_ready,
    input  wire logic [FREQ_W-1:0]          i_freq,
    input  wire logic                       i_sample_valid,
    input  wire logic                       i_sample_ready,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic                       i_last,
    input  wire logic                       i_psel,
    input  wire logic                       i_penable,
    input  wire logic                       i_pwrite,
    input  wire logic [APB_ADDR_W-1:0]      i_paddr,
    input  wire logic [APB_DATA_W-1:0]      i_pwdata,
    input  wire logic [APB_DATA_W-1:0]      i_prdata,
    input  wire logic                       i_pready,
    input  wire logic                       i_done,
    output int                              o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [FR_W-1:0] RESET_RATE = FR_W'(48000);
    localparam int              MAX_PRINTS = 100;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_chunk_sample;

    t_chunk_sample         pending_samples[$];
    int                    quarter_sine [0:TAB_N];
    logic [SHAPE_W-1:0]    shape_q;
    logic [FR_W-1:0]       rate_q;
    logic [PHASE_BITS-1:0] phase_q;
    int                    fail_count = 0;
    bit                    done_seen  = 1'b0;

    assign o_fail_count = fail_count;

    // Quarter-wave entry k: Taylor series of sin in Q30, rounded to Q15
    function automatic int quarter_entry(input int k);
        logic [63:0] x;
        logic [63:0] term;
        longint      sum;
        longint      v;
        int          n;
        x    = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
        term = x;
        sum  = longint'(x);
        for (n = 1; n <= 7; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / (64'(2 * n) * 64'(2 * n + 1));
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (sum + 16384) >>> 15;
        if (v > 32767) begin
            v = 32767;
        end
        return int'(v);
    endfunction

    initial begin
        for (int k = 0; k <= TAB_N; k++) begin
            quarter_sine[k] = quarter_entry(k);
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] wave_value(input logic [PHASE_BITS-1:0] p);
        logic [SINE_TABLE_BITS+1:0] idx;
        logic [1:0]                 quad;
        int                         f;
        idx  = p[PHASE_BITS-1 -: SINE_TABLE_BITS+2];
        quad = idx[SINE_TABLE_BITS+1 -: 2];
        f    = int'(idx[SINE_TABLE_BITS-1:0]);
        case (shape_q)
            SHAPE_SINE: begin
                case (quad)
                    2'd0:    return SAMPLE_W'(quarter_sine[f]);
                    2'd1:    return SAMPLE_W'(quarter_sine[TAB_N - f]);
                    2'd2:    return SAMPLE_W'(-quarter_sine[f]);
                    default: return SAMPLE_W'(-quarter_sine[TAB_N - f]);
                endcase
            end
            SHAPE_SQUARE: return p[PHASE_BITS-1] ? 16'sh7FFF : 16'sh8000;
            SHAPE_SAW:    return {~p[PHASE_BITS-1], p[PHASE_BITS-2 -: SAMPLE_W-1]};
            default:      return '0;
        endcase
    endfunction

    // Rounded |freq| * 2^(PHASE_BITS-8) / frame_rate, sign applied modulo one turn
    function automatic logic [PHASE_BITS-1:0] phase_step(input logic [FREQ_W-1:0] f);
        logic [63:0] mag;
        logic [63:0] num;
        logic [63:0] inc;
        mag = f[FREQ_W-1] ? ((64'd1 << FREQ_W) - 64'(f)) : 64'(f);
        num = mag << (PHASE_BITS - FREQ_FRAC);
        inc = '0;
        if (rate_q != '0) begin
            inc = (num + 64'(rate_q >> 1)) / 64'(rate_q);
        end
        if (f[FREQ_W-1]) begin
            inc = -inc;
        end
        return inc[PHASE_BITS-1:0];
    endfunction

    task automatic predict_chunk(input logic [FREQ_W-1:0] f);
        logic [PHASE_BITS-1:0] inc;
        t_chunk_sample         s;
        inc = phase_step(f);
        for (int i = 0; i < CHUNK_SIZE; i++) begin
            s.sample = wave_value(phase_q);
            s.last   = (i == CHUNK_SIZE - 1);
            pending_samples.push_back(s);
            phase_q = phase_q + inc;
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTS) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
        fail_count++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_chunk_sample         want;
        logic [APB_DATA_W-1:0] reg_want;
        if (!i_rst_n) begin
            shape_q = SHAPE_SINE;
            rate_q  = RESET_RATE;
            phase_q = '0;
            pending_samples.delete();
        end else begin
            // Retire samples before queuing a new chunk taken at the same edge
            if (i_sample_valid && i_sample_ready) begin
                if (pending_samples.size() == 0) begin
                    report_mismatch($sformatf("sample %0d arrived with nothing pending",
                                              i_sample));
                end else begin
                    want = pending_samples.pop_front();
                    if (i_sample !== want.sample) begin
                        report_mismatch($sformatf("sample expected %0d got %0d",
                                                  want.sample, i_sample));
                    end
                    if (i_last !== want.last) begin
                        report_mismatch($sformatf("last expected %0b got %0b",
                                                  want.last, i_last));
                    end
                end
            end
            if (i_freq_valid && i_freq_ready) begin
                predict_chunk(i_freq);
            end
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (i_paddr[APB_ADDR_W-1:2])
                        REG_SHAPE:      shape_q = i_pwdata[SHAPE_W-1:0];
                        REG_FRAME_RATE: rate_q  = i_pwdata[FR_W-1:0];
                        default: ;
                    endcase
                end else begin
                    case (i_paddr[APB_ADDR_W-1:2])
                        REG_SHAPE:      reg_want = APB_DATA_W'(shape_q);
                        default:        reg_want = APB_DATA_W'(rate_q);
                    endcase
                    if (i_prdata !== reg_want) begin
                        report_mismatch($sformatf("read of 0x%0h expected 0x%0h got 0x%0h",
                                                  i_paddr, reg_want, i_prdata));
                    end
                end
            end
            if (i_done && !done_seen) begin
                done_seen = 1'b1;
                if (pending_samples.size() != 0) begin
                    report_mismatch($sformatf("%0d samples never arrived",
                                              pending_samples.size()));
                end
            end
        end
    end

endmodule

FILE: verif/waveform_oscillator_tb.sv
// Top of the waveform oscillator testbench: clock, reset, frequency and APB stimulus,
// a randomly stalling sample sink, a watchdog and the verdict.
// Depends on wosc_pkg, waveform_oscillator and wosc_checker.
module waveform_oscillator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wosc_pkg::*;

    localparam int RANDOM_ITEMS   = 400;
    localparam int CALM_ITEMS     = 60;     // tail of the run without idling
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transaction on any port
    localparam int DRAIN_PAD      = 8;

    localparam logic [APB_ADDR_W-1:0] ADDR_SHAPE = APB_ADDR_W'(int'(REG_SHAPE) * 4);
    localparam logic [APB_ADDR_W-1:0] ADDR_RATE  = APB_ADDR_W'(int'(REG_FRAME_RATE) * 4);

    logic                       i_clk;
    logic                       i_rst_n        = 1'b0;
    logic                       i_freq_valid   = 1'b0;
    logic                       o_freq_ready;
    logic signed [FREQ_W-1:0]   i_freq         = '0;
    logic                       o_sample_valid;
    logic                       i_sample_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample;
    logic                       o_last;
    logic                       i_psel         = 1'b0;
    logic                       i_penable      = 1'b0;
    logic                       i_pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0]      i_paddr        = '0;
    logic [APB_DATA_W-1:0]      i_pwdata       = '0;
    logic [APB_DATA_W-1:0]      o_prdata;
    logic                       o_pready;

    logic idle_en  = 1'b1;
    logic run_done = 1'b0;
    int   fail_count;
    int   freq_sent    = 0;
    int   samples_seen = 0;
    int   quiet_cycles = 0;
    int   sink_stall   = 0;

    waveform_oscillator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_freq_valid   (i_freq_valid),
        .o_freq_ready   (o_freq_ready),
        .i_freq         (i_freq),
        .o_sample_valid (o_sample_valid),
        .i_sample_ready (i_sample_ready),
        .o_sample       (o_sample),
        .o_last         (o_last),
        .i_psel         (i_psel),
        .i_penable      (i_penable),
        .i_pwrite       (i_pwrite),
        .i_paddr        (i_paddr),
        .i_pwdata       (i_pwdata),
        .o_prdata       (o_prdata),
        .o_pready       (o_pready)
    );

    wosc_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_freq_valid   (i_freq_valid),
        .i_freq_ready   (o_freq_ready),
        .i_freq         (i_freq),
        .i_sample_valid (o_sample_valid),
        .i_sample_ready (i_sample_ready),
        .i_sample       (o_sample),
        .i_last         (o_last),
        .i_psel         (i_psel),
        .i_penable      (i_penable),
        .i_pwrite       (i_pwrite),
        .i_paddr        (i_paddr),
        .i_pwdata       (i_pwdata),
        .i_prdata       (o_prdata),
        .i_pready       (o_pready),
        .i_done         (run_done),
        .o_fail_count   (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Sample sink: drop ready at random and hold it low for a random burst while idling is enabled,
    // otherwise keep it high. One assignment per edge.
    always @(posedge i_clk) begin
        if (sink_stall != 0) begin
            i_sample_ready <= 1'b0;
            sink_stall     <= sink_stall - 1;
        end else if (idle_en && $urandom_range(0, 15) == 0) begin
            i_sample_ready <= 1'b0;
            sink_stall     <= $urandom_range(1, 13) - 1;
        end else begin
            i_sample_ready <= 1'b1;
        end
    end

    // Count delivered samples and watch for a stuck block: any transaction on any port
    // clears the quiet counter.
    always @(posedge i_clk) begin
        if (o_sample_valid && i_sample_ready) begin
            samples_seen <= samples_seen + 1;
        end
        if (!i_rst_n || (i_freq_valid && o_freq_ready) || (o_sample_valid && i_sample_ready)
                || (i_psel && i_penable && o_pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic signed [FREQ_W-1:0] hz(input int whole);
        return FREQ_W'(whole * (1 << FREQ_FRAC));
    endfunction

    // Offer one frequency and return at the edge that accepts it. Valid stays high on
    // return so a back-to-back item never drops it within the same step.
    task automatic send_freq(input logic signed [FREQ_W-1:0] f);
        if (idle_en && $urandom_range(0, 2) == 0) begin
            i_freq_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_freq_valid <= 1'b1;
        i_freq       <= f;
        do @(posedge i_clk); while (!o_freq_ready);
        freq_sent++;
    endtask

    // Drop valid and hold until every predicted sample has been delivered
    task automatic wait_drain();
        i_freq_valid <= 1'b0;
        while (samples_seen != freq_sent * CHUNK_SIZE) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // One APB transaction: setup cycle, then access until pready
    task automatic apb_xfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= wr;
        i_paddr   <= addr;
        i_pwdata  <= data;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write both registers, with random junk above the field half the time, then read
    // them back. Call only once the block has drained.
    task automatic set_config(input logic [SHAPE_W-1:0] shape, input logic [FR_W-1:0] rate);
        logic [APB_DATA_W-1:0] junk;
        junk = $urandom_range(0, 1) ? APB_DATA_W'($urandom()) : '0;
        apb_xfer(1'b1, ADDR_SHAPE, (junk << SHAPE_W) | APB_DATA_W'(shape));
        junk = $urandom_range(0, 1) ? APB_DATA_W'($urandom()) : '0;
        apb_xfer(1'b1, ADDR_RATE, (junk << FR_W) | APB_DATA_W'(rate));
        apb_xfer(1'b0, ADDR_SHAPE, '0);
        apb_xfer(1'b0, ADDR_RATE, '0);
    endtask

    initial begin : stimulus
        logic signed [FREQ_W-1:0] f;
        logic [SHAPE_W-1:0]       shape;
        logic [FR_W-1:0]          rate;
        int                       done_items;
        int                       phase_len;

        // Hold reset, then release it once
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values of both registers, then sine at 48 kHz straight out of reset:
        // zero, the smallest steps either way, a musical tone, both frequency extremes and 12 kHz
        apb_xfer(1'b0, ADDR_SHAPE, '0);
        apb_xfer(1'b0, ADDR_RATE, '0);
        send_freq('0);
        send_freq(FREQ_W'(1));
        send_freq(-FREQ_W'(1));
        send_freq(hz(440));
        send_freq(24'sh7FFFFF);
        send_freq(24'sh800000);
        send_freq(hz(12000));
        wait_drain();

        // Square at the slowest frame rate; half the rate toggles every sample, and a
        // frequency above the rate wraps the increment
        set_config(SHAPE_SQUARE, FR_W'(1000));
        send_freq(hz(250));
        send_freq(hz(500));
        send_freq(hz(5000));
        send_freq(-hz(300));
        wait_drain();

        // Sawtooth at the fastest legal frame rate
        set_config(SHAPE_SAW, FR_W'(192000));
        send_freq(24'sh7FFFFF);
        send_freq(24'sh800000);
        send_freq(hz(1000) + FREQ_W'(129));
        wait_drain();

        // Unused shape code gives silence while the phase still advances
        set_config(2'd3, FR_W'(48000));
        send_freq(hz(3000));
        send_freq(-hz(7777));
        wait_drain();

        // Zero frame rate: the phase holds wherever the last chunk left it
        set_config(SHAPE_SINE, '0);
        send_freq(hz(440));
        send_freq(24'sh800000);
        wait_drain();

        // Largest value the rate field can hold
        set_config(SHAPE_SINE, '1);
        send_freq(24'sh7FFFFF);
        send_freq(-hz(20000));
        wait_drain();

        // Random phases: fresh settings each time, idling off for the tail of the run
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            shape = SHAPE_W'($urandom_range(0, 3));
            case ($urandom_range(0, 7))
                0:       rate = '0;
                1:       rate = FR_W'($urandom());
                2:       rate = FR_W'(1000);
                3:       rate = FR_W'(192000);
                default: rate = FR_W'($urandom_range(1000, 192000));
            endcase
            set_config(shape, rate);
            phase_len = $urandom_range(20, 45);
            if (phase_len > RANDOM_ITEMS - done_items) begin
                phase_len = RANDOM_ITEMS - done_items;
            end
            for (int i = 0; i < phase_len; i++) begin
                if (done_items >= RANDOM_ITEMS - CALM_ITEMS) begin
                    idle_en <= 1'b0;
                end
                case ($urandom_range(0, 3))
                    0: f = FREQ_W'($urandom());
                    1: f = hz(int'($urandom_range(0, 20000))) + FREQ_W'($urandom_range(0, 255));
                    2: f = -(hz(int'($urandom_range(0, 20000)))
                             + FREQ_W'($urandom_range(0, 255)));
                    default: begin
                        case ($urandom_range(0, 3))
                            0:       f = 24'sh7FFFFF;
                            1:       f = 24'sh800000;
                            2:       f = FREQ_W'(1);
                            default: f = -FREQ_W'(1);
                        endcase
                    end
                endcase
                send_freq(f);
                done_items++;
                // Now and then hold the sender until the block has fully drained
                if (idle_en && $urandom_range(0, 39) == 0) begin
                    wait_drain();
                end
            end
            wait_drain();
        end

        // Let the checker look for leftovers, then give the verdict
        run_done <= 1'b1;
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: waveform_oscillator.f
rtl/core/wosc_pkg.sv
rtl/core/wosc_regs.sv
rtl/core/wosc_div.sv
rtl/core/wosc_wave.sv
rtl/core/waveform_oscillator.sv
rtl/core/wosc_chk.sv
verif/wosc_checker.sv
verif/waveform_oscillator_tb.sv
